// ===== src/ttip_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text to integer parser package
// Shared widths, phase codes, character codes, payload types and helpers.
// ----------------------------------------------------------------------------
package ttip_pkg;

   localparam int VALUE_BITS     = 64;
   localparam int COUNT_BITS     = 16;
   localparam int RADIX_BITS     = 6;
   localparam int DIGIT_BITS     = 6;
   localparam int PHASE_BITS     = 3;
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 8;
   localparam int PROD_BITS      = VALUE_BITS + RADIX_BITS + 1;

   localparam logic [PHASE_BITS-1:0] PH_SPACE  = 3'd0;
   localparam logic [PHASE_BITS-1:0] PH_SIGNED = 3'd1;
   localparam logic [PHASE_BITS-1:0] PH_ZERO   = 3'd2;
   localparam logic [PHASE_BITS-1:0] PH_DIGITS = 3'd3;
   localparam logic [PHASE_BITS-1:0] PH_DONE   = 3'd4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_RADIX       = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIGNED_MODE = 8'd1;

   localparam logic [RADIX_BITS-1:0] BASE_AUTO   = 6'd0;
   localparam logic [RADIX_BITS-1:0] BASE_MIN    = 6'd2;
   localparam logic [RADIX_BITS-1:0] BASE_OCT    = 6'd8;
   localparam logic [RADIX_BITS-1:0] BASE_DEC    = 6'd10;
   localparam logic [RADIX_BITS-1:0] BASE_HEX    = 6'd16;
   localparam logic [RADIX_BITS-1:0] BASE_MAX    = 6'd36;
   localparam logic [RADIX_BITS-1:0] RADIX_RESET = BASE_DEC;

   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_X = 8'h58;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_X = 8'h78;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] LETTER_BIAS = 8'd10;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   typedef struct packed {
      logic [7:0] ch;
      logic       first;
   } ttip_req_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic [COUNT_BITS-1:0] consumed;
      logic                  range_error;
   } ttip_rsp_type;

   typedef struct packed {
      logic [PHASE_BITS-1:0] phase;
      logic [VALUE_BITS-1:0] accumulator;
      logic                  is_negative;
      logic                  seen_digit;
      logic                  overflowed;
      logic [RADIX_BITS-1:0] active_base;
      logic [COUNT_BITS-1:0] position;
   } ttip_state_type;

   localparam ttip_state_type STATE_CLEAR = '{
      phase:       PH_SPACE,
      accumulator: '0,
      is_negative: 1'b0,
      seen_digit:  1'b0,
      overflowed:  1'b0,
      active_base: BASE_AUTO,
      position:    '0
   };

   function automatic logic [COUNT_BITS-1:0] count_inc(input logic [COUNT_BITS-1:0] pos);
      count_inc = (pos == COUNT_MAX) ? pos : pos + 1'b1;
   endfunction

   // Returns the digit value; the upper bit flags a character that is a digit in some base.
   function automatic logic [DIGIT_BITS:0] digit_of(input logic [7:0] c);
      logic [7:0] t;
      t = 8'd0;
      digit_of = '0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         t = c - CH_ZERO;
         digit_of = {1'b1, t[DIGIT_BITS-1:0]};
      end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
         t = c - CH_UPPER_A + LETTER_BIAS;
         digit_of = {1'b1, t[DIGIT_BITS-1:0]};
      end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
         t = c - CH_LOWER_A + LETTER_BIAS;
         digit_of = {1'b1, t[DIGIT_BITS-1:0]};
      end
   endfunction

endpackage

// ===== src/ttip_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text to integer parser step logic
// Computes the next parse state and the optional result for one character.
// ----------------------------------------------------------------------------
module ttip_step (
   input  ttip_pkg::ttip_req_type           req,
   input  ttip_pkg::ttip_state_type         state_cur,
   input  logic [ttip_pkg::RADIX_BITS-1:0]  radix,
   input  logic                             signed_mode,
   output ttip_pkg::ttip_state_type         state_nxt,
   output logic                             emit,
   output ttip_pkg::ttip_rsp_type           rsp
);
   import ttip_pkg::*;

   ttip_state_type        cur;
   logic                  start;
   logic                  take;
   logic                  seen_t;
   logic [RADIX_BITS-1:0] base_t;
   logic [DIGIT_BITS:0]   dig;
   logic                  digit_ok;
   logic [PROD_BITS-1:0]  prod;
   logic                  prod_ovf;
   logic                  is_space;
   logic [VALUE_BITS-1:0] neg_acc;
   logic                  top_bit;
   logic                  low_bits;

   assign is_space = (req.ch == CH_SPACE) || (req.ch >= CH_TAB && req.ch <= CH_CR);

   always_comb begin
      cur       = req.first ? STATE_CLEAR : state_cur;
      state_nxt = cur;
      start     = 1'b0;
      take      = 1'b0;
      seen_t    = cur.seen_digit;
      base_t    = cur.active_base;
      emit      = 1'b0;
      dig       = digit_of(req.ch);
      digit_ok  = 1'b0;
      prod      = '0;
      prod_ovf  = 1'b0;

      case (cur.phase)
         PH_SPACE: begin
            if (is_space) begin
               state_nxt.position = count_inc(cur.position);
            end else if (req.ch == CH_MINUS || req.ch == CH_PLUS) begin
               state_nxt.is_negative = (req.ch == CH_MINUS);
               state_nxt.position    = count_inc(cur.position);
               state_nxt.phase       = PH_SIGNED;
            end else begin
               start = 1'b1;
            end
         end
         PH_SIGNED: begin
            start = 1'b1;
         end
         PH_ZERO: begin
            if (req.ch == CH_LOWER_X || req.ch == CH_UPPER_X) begin
               state_nxt.position    = count_inc(cur.position);
               state_nxt.active_base = BASE_HEX;
               state_nxt.phase       = PH_DIGITS;
            end else begin
               seen_t = 1'b1;
               base_t = (cur.active_base == BASE_AUTO) ? BASE_OCT : BASE_HEX;
               take   = 1'b1;
            end
         end
         PH_DIGITS: begin
            take = 1'b1;
         end
         default: begin
         end
      endcase

      if (start) begin
         if ((radix == BASE_AUTO || radix == BASE_HEX) && req.ch == CH_ZERO) begin
            state_nxt.active_base = radix;
            state_nxt.phase       = PH_ZERO;
            state_nxt.position    = count_inc(cur.position);
         end else begin
            base_t = (radix == BASE_AUTO) ? BASE_DEC : radix;
            take   = 1'b1;
         end
      end

      digit_ok = dig[DIGIT_BITS] && (base_t >= BASE_MIN) && (base_t <= BASE_MAX)
                 && (dig[DIGIT_BITS-1:0] < base_t);
      prod = {{(RADIX_BITS + 1){1'b0}}, cur.accumulator}
             * {{(VALUE_BITS + 1){1'b0}}, base_t}
             + {{(PROD_BITS - DIGIT_BITS){1'b0}}, dig[DIGIT_BITS-1:0]};
      prod_ovf = |prod[PROD_BITS-1:VALUE_BITS];

      if (take) begin
         state_nxt.active_base = base_t;
         state_nxt.seen_digit  = seen_t;
         state_nxt.phase       = PH_DIGITS;
         if (!digit_ok) begin
            emit            = 1'b1;
            state_nxt.phase = PH_DONE;
         end else begin
            state_nxt.position   = count_inc(cur.position);
            state_nxt.seen_digit = 1'b1;
            if (!cur.overflowed) begin
               if (prod_ovf) begin
                  state_nxt.overflowed = 1'b1;
               end else begin
                  state_nxt.accumulator = prod[VALUE_BITS-1:0];
               end
            end
         end
      end
   end

   assign neg_acc  = '0 - cur.accumulator;
   assign top_bit  = cur.accumulator[VALUE_BITS-1];
   assign low_bits = |cur.accumulator[VALUE_BITS-2:0];

   always_comb begin
      rsp.value       = '0;
      rsp.range_error = 1'b0;
      rsp.consumed    = seen_t ? cur.position : '0;
      if (!seen_t) begin
         rsp.value = '0;
      end else if (!signed_mode) begin
         if (cur.overflowed) begin
            rsp.value       = '1;
            rsp.range_error = 1'b1;
         end else begin
            rsp.value = cur.is_negative ? neg_acc : cur.accumulator;
         end
      end else if (cur.overflowed) begin
         rsp.value       = '0;
         rsp.range_error = 1'b1;
      end else if (cur.is_negative) begin
         if (top_bit && low_bits) begin
            rsp.value       = '1;
            rsp.range_error = 1'b1;
         end else begin
            rsp.value = neg_acc;
         end
      end else if (top_bit) begin
         rsp.value       = '1;
         rsp.range_error = 1'b1;
      end else begin
         rsp.value = cur.accumulator;
      end
   end

endmodule

// ===== src/text_to_integer_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text to integer parser unit
// Streams ASCII characters in and returns one 64-bit integer per string.
// ----------------------------------------------------------------------------
// A string is sent one character per req transaction; first marks its start.
// Leading white space, one sign and a base prefix are handled, then digits.
// The first character that is not a digit of the active base produces one
// rsp transaction with the value, the consumed count and the range flag.
// Other characters produce no rsp transaction.
// Registers must be written over the csr channel only while the unit is
// idle; the unit does not enforce this. Index 0 sets the radix, index 1
// selects signed conversion. A character enters an input register, is
// evaluated against the parse state, and its result lands in the output
// register. One character is accepted every cycle unless a result waits
// on a stalled rsp; the loop that updates the parse state through the
// digit multiply-add sets that rate.
// When rsp is stalled, characters that produce no result keep flowing; a
// character that ends a number waits in the input register.
// Reset clears the parse state, sets the radix to 10 and unsigned mode.
// ----------------------------------------------------------------------------
module text_to_integer_parser_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  ttip_pkg::ttip_req_type               req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output ttip_pkg::ttip_rsp_type               rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ttip_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [ttip_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import ttip_pkg::*;

   logic                  s1_valid_ff, s1_valid_in;
   ttip_req_type          s1_data_ff;
   ttip_state_type        state_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   ttip_rsp_type          rsp_data_ff;
   logic [RADIX_BITS-1:0] radix_ff;
   logic                  signed_mode_ff;

   ttip_state_type        state_nxt;
   ttip_rsp_type          step_rsp;
   logic                  step_emit;
   logic                  advance;

   ttip_step u_step (
      .req         (s1_data_ff),
      .state_cur   (state_ff),
      .radix       (radix_ff),
      .signed_mode (signed_mode_ff),
      .state_nxt   (state_nxt),
      .emit        (step_emit),
      .rsp         (step_rsp)
   );

   assign advance   = s1_valid_ff && (!step_emit || !rsp_valid_ff || rsp_ready);
   assign req_ready = !reset && (!s1_valid_ff || advance);
   assign csr_ready = !reset;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance && step_emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         state_ff       <= STATE_CLEAR;
         radix_ff       <= RADIX_RESET;
         signed_mode_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_nxt;
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_RADIX) begin
               radix_ff <= csr_data[RADIX_BITS-1:0];
            end else if (csr_index == CSR_SIGNED_MODE) begin
               signed_mode_ff <= csr_data[0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_data_ff <= req_data;
      end
      if (advance && step_emit) begin
         rsp_data_ff <= step_rsp;
      end
   end

endmodule
